// ----- design/rps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rps_pkg;

    localparam int MAX_ROW = 64;
    localparam int ADDR_W  = $clog2(MAX_ROW);
    localparam int LEN_W   = 7;
    localparam int ACC_W   = 48;

    localparam logic [1:0] REG_ROW_LENGTH = 2'd0;
    localparam logic [1:0] REG_EXCLUSIVE  = 2'd1;
    localparam logic [1:0] REG_REVERSE    = 2'd2;

    localparam logic [15:0] FP16_QNAN = 16'h7E00;
    localparam logic [15:0] FP16_PINF = 16'h7C00;
    localparam logic [15:0] FP16_NINF = 16'hFC00;

    // Exact running sum, LSB 2^-24, with sticky non-finite flags.
    typedef struct packed {
        logic signed [ACC_W-1:0] acc;
        logic                    pinf;
        logic                    ninf;
        logic                    nan;
    } sum_t;

    typedef struct packed {
        sum_t              sum;
        logic [ADDR_W-1:0] pos;
        logic              last;
    } conv_req_t;

    // Add one fp16 value into a running sum.
    function automatic sum_t sum_add(sum_t s, logic [15:0] b);
        sum_t             r;
        logic [4:0]       e;
        logic [9:0]       f;
        logic [ACC_W-1:0] mag;
        r   = s;
        e   = b[14:10];
        f   = b[9:0];
        mag = '0;
        if (e == 5'd31) begin
            if (f != 10'd0) begin
                r.nan = 1'b1;
            end else if (b[15]) begin
                r.ninf = 1'b1;
            end else begin
                r.pinf = 1'b1;
            end
        end else begin
            if (e == 5'd0) begin
                mag = ACC_W'(f);
            end else begin
                mag = ACC_W'({1'b1, f}) << (e - 5'd1);
            end
            if (b[15]) begin
                r.acc = s.acc - signed'(mag);
            end else begin
                r.acc = s.acc + signed'(mag);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/rps_row_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rps_row_mem (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic [rps_pkg::ADDR_W-1:0] wr_addr,
    input  wire logic [15:0]                wr_data,
    input  wire logic                       rd_en,
    input  wire logic [rps_pkg::ADDR_W-1:0] rd_addr,
    output logic      [15:0]                rd_data
);

    logic [15:0] row_mem [rps_pkg::MAX_ROW];
    logic [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= row_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- design/rps_fp16_round.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Fixed-point sum to fp16, nearest-even. Five stages plus the output
// register; the whole pipe holds while stage 5 waits on a blocked output.
module rps_fp16_round (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire rps_pkg::conv_req_t    req,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [23:0]                m_tdata,
    output logic                       m_tlast
);

    localparam int MAG_W = rps_pkg::ACC_W - 1;

    typedef struct packed {
        logic                       sign;
        logic [MAG_W-1:0]           mag;
        logic                       direct;
        logic [15:0]                word;
        logic [rps_pkg::ADDR_W-1:0] pos;
        logic                       last;
        logic [2:0]                 grp;
        logic [5:0]                 msb;
        logic [11:0]                m12;
        logic                       sticky;
    } cv_t;

    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    rps_pkg::conv_req_t s1_reg;
    cv_t                s2_reg, s3_reg, s4_reg, s5_reg;
    cv_t                s2_next, s3_next, s4_next, s5_next;
    logic               out_valid_reg;
    logic [15:0]        out_sum_reg, out_sum_next;
    logic [rps_pkg::ADDR_W-1:0] out_pos_reg;
    logic               out_last_reg;
    logic               stall;

    assign stall     = s5_valid_reg && out_valid_reg && !m_tready;
    assign req_ready = !stall;

    // Stage 2: magnitude and the cases that need no rounding.
    always_comb begin
        logic [rps_pkg::ACC_W-1:0] absv;
        s2_next      = '0;
        absv         = s1_reg.sum.acc[rps_pkg::ACC_W-1] ? -s1_reg.sum.acc : s1_reg.sum.acc;
        s2_next.sign = s1_reg.sum.acc[rps_pkg::ACC_W-1];
        s2_next.mag  = absv[MAG_W-1:0];
        s2_next.pos  = s1_reg.pos;
        s2_next.last = s1_reg.last;
        s2_next.direct = 1'b1;
        if (s1_reg.sum.nan || (s1_reg.sum.pinf && s1_reg.sum.ninf)) begin
            s2_next.word = rps_pkg::FP16_QNAN;
        end else if (s1_reg.sum.pinf) begin
            s2_next.word = rps_pkg::FP16_PINF;
        end else if (s1_reg.sum.ninf) begin
            s2_next.word = rps_pkg::FP16_NINF;
        end else if (absv[rps_pkg::ACC_W-1:11] == '0) begin
            // Below 2048 the fixed-point value maps straight onto fp16 bits.
            s2_next.word = (absv == '0) ? 16'h0000 : {s2_next.sign, 4'd0, absv[10:0]};
        end else begin
            s2_next.direct = 1'b0;
        end
    end

    // Stage 3: highest nonzero byte.
    always_comb begin
        logic [47:0] mag48;
        s3_next = s2_reg;
        mag48   = 48'(s2_reg.mag);
        for (int k = 0; k < 6; k++) begin
            if (mag48[8*k +: 8] != 8'd0) begin
                s3_next.grp = 3'(k);
            end
        end
    end

    // Stage 4: highest set bit inside that byte.
    always_comb begin
        logic [47:0] mag48;
        logic [7:0]  byte_v;
        logic [2:0]  hb;
        s4_next = s3_reg;
        mag48   = 48'(s3_reg.mag);
        byte_v  = mag48[{s3_reg.grp, 3'b000} +: 8];
        hb      = 3'd0;
        for (int b = 0; b < 8; b++) begin
            if (byte_v[b]) begin
                hb = 3'(b);
            end
        end
        s4_next.msb = {s3_reg.grp, hb};
    end

    // Stage 5: align to 11 mantissa bits plus a round bit, collect sticky.
    always_comb begin
        logic [5:0]       sh;
        logic [MAG_W-1:0] t;
        logic [MAG_W-1:0] mask;
        s5_next        = s4_reg;
        sh             = s4_reg.msb - 6'd11;
        t              = s4_reg.mag >> sh;
        mask           = (MAG_W'(1) << sh) - MAG_W'(1);
        s5_next.m12    = t[11:0];
        s5_next.sticky = |(s4_reg.mag & mask);
    end

    // Output: round, carry into the exponent, saturate to infinity.
    always_comb begin
        logic        up;
        logic [11:0] mr;
        logic [6:0]  ex;
        up = s5_reg.m12[0] & (s5_reg.sticky | s5_reg.m12[1]);
        mr = {1'b0, s5_reg.m12[11:1]} + 12'(up);
        ex = 7'(s5_reg.msb) - 7'd9 + 7'(mr[11]);
        if (s5_reg.direct) begin
            out_sum_next = s5_reg.word;
        end else if (ex >= 7'd31) begin
            out_sum_next = {s5_reg.sign, rps_pkg::FP16_PINF[14:0]};
        end else begin
            out_sum_next = {s5_reg.sign, ex[4:0], mr[9:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (!stall) begin
            s1_valid_reg  <= req_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= s5_valid_reg || (out_valid_reg && !m_tready);
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            s1_reg <= req;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            if (s5_valid_reg) begin
                out_sum_reg  <= out_sum_next;
                out_pos_reg  <= s5_reg.pos;
                out_last_reg <= s5_reg.last;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_pos_reg, out_sum_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- design/row_prefix_sum_fp16.sv -----
`timescale 1ns / 1ps
`default_nettype none

// ST_ADD hands a forward result to the rounder; after a reverse row ends, ST_READ and
//   ST_SCAN pass each suffix result to it. A request is taken only in ST_IDLE, after
//   the last one is accumulated; forward ST_ADD and ST_SCAN wait on a stalled rounder.
//   A reverse row drains one result per read, scan pass on the single row-buffer port.
// Reset (aresetn, synchronous, active low) clears control, sums, counters and config
//   (row_length 64, inclusive, forward); the row buffer is not cleared.
module row_prefix_sum_fp16 (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,     // [15:0] value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,     // [15:0] sum, [21:16] position, [23:22] zero
    output logic             m_tlast,     // row_last
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [6:0]  cfg_wdata
);

    localparam int AW = rps_pkg::ADDR_W;
    localparam int LW = rps_pkg::LEN_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,   // wait for the next request
        ST_ADD  = 4'b0010,   // fold the element into the forward sum
        ST_READ = 4'b0100,   // fetch one buffered element of the row
        ST_SCAN = 4'b1000    // extend the suffix sum and hand it to the rounder
    } state_t;

    state_t            state_reg, state_next;

    // Configuration; the user must write it only while idle, the block does not enforce it.
    logic [LW-1:0]     row_length_reg;
    logic              excl_reg;
    logic              rev_reg;

    logic [AW-1:0]     count_reg, count_next;
    logic [15:0]       value_reg;
    logic [AW-1:0]     pos_reg;
    logic              last_reg;
    logic [AW-1:0]     idx_reg, idx_next;
    rps_pkg::sum_t     fwd_reg, fwd_next;
    rps_pkg::sum_t     sfx_reg, sfx_next;

    logic              in_accept;
    logic [LW-1:0]     len_eff;
    logic              in_last;
    logic [15:0]       rd_data;
    rps_pkg::sum_t     fwd_add, sfx_add;

    rps_pkg::conv_req_t conv_req;
    logic               conv_valid;
    logic               conv_ready;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // Clamp the row length into 1..MAX_ROW; the row ends when this element
    // reaches it (also when the length was lowered below the elements taken).
    always_comb begin
        if (row_length_reg == '0) begin
            len_eff = LW'(1);
        end else if (row_length_reg > LW'(rps_pkg::MAX_ROW)) begin
            len_eff = LW'(rps_pkg::MAX_ROW);
        end else begin
            len_eff = row_length_reg;
        end
    end
    assign in_last = ((LW'(count_reg) + LW'(1)) >= len_eff);

    assign fwd_add = rps_pkg::sum_add(fwd_reg, value_reg);
    assign sfx_add = rps_pkg::sum_add(sfx_reg, rd_data);

    // Config write port; indexes past the list drop silently.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg <= LW'(rps_pkg::MAX_ROW);
            excl_reg       <= 1'b0;
            rev_reg        <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rps_pkg::REG_ROW_LENGTH: row_length_reg <= cfg_wdata;
                rps_pkg::REG_EXCLUSIVE:  excl_reg       <= cfg_wdata[0];
                rps_pkg::REG_REVERSE:    rev_reg        <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Every element goes into the row buffer at its position, whatever the mode,
    // so a mode change mid-row still drains a complete row.
    rps_row_mem u_row_mem (
        .aclk    (aclk),
        .wr_en   (in_accept),
        .wr_addr (count_reg),
        .wr_data (s_tdata),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        fwd_next   = fwd_reg;
        sfx_next   = sfx_reg;
        conv_valid = 1'b0;
        conv_req   = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    count_next = in_last ? '0 : count_reg + AW'(1);
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                if (!rev_reg) begin
                    // Forward: emit the prefix before or after this element.
                    conv_req.sum  = excl_reg ? fwd_reg : fwd_add;
                    conv_req.pos  = pos_reg;
                    conv_req.last = last_reg;
                    if (conv_ready) begin
                        conv_valid = 1'b1;
                        fwd_next   = last_reg ? '0 : fwd_add;
                        state_next = ST_IDLE;
                    end
                end else begin
                    fwd_next = last_reg ? '0 : fwd_add;
                    if (last_reg) begin
                        // Drain from this position down to 0 with a fresh suffix sum.
                        idx_next   = pos_reg;
                        sfx_next   = '0;
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                conv_req.sum  = excl_reg ? sfx_reg : sfx_add;
                conv_req.pos  = idx_reg;
                conv_req.last = (idx_reg == '0);
                if (conv_ready) begin
                    conv_valid = 1'b1;
                    sfx_next   = sfx_add;
                    if (idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg - AW'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            fwd_reg   <= '0;
            sfx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            fwd_reg   <= fwd_next;
            sfx_reg   <= sfx_next;
        end
    end

    // Hold the accepted element and where it sits in the row.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            value_reg <= s_tdata;
            pos_reg   <= count_reg;
            last_reg  <= in_last;
        end
    end

    rps_fp16_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (conv_req),
        .req_valid (conv_valid),
        .req_ready (conv_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

// One expected output: fp16 sum, position in the row, last-of-row flag.
typedef struct packed {
    logic [15:0] sum;
    logic [5:0]  pos;
    logic        last;
} scan_out_t;

// Exact running sum in units of 2^-24 plus sticky non-finite flags.
typedef struct packed {
    logic signed [63:0] acc;
    logic               pinf;
    logic               ninf;
    logic               nan_seen;
} run_t;

class fp16_scan_scoreboard;
    logic [6:0]  row_len;
    bit          excl_on;
    bit          reverse_on;
    run_t        fwd;
    int          taken;
    logic [15:0] row_store [rps_pkg::MAX_ROW];
    scan_out_t   sums_due [$];
    int unsigned errors;

    function new();
        row_len    = 7'd64;
        excl_on    = 1'b0;
        reverse_on = 1'b0;
        fwd        = '0;
        taken      = 0;
        errors     = 0;
    endfunction

    function void set_config(logic [6:0] len, bit excl, bit rev);
        row_len    = len;
        excl_on    = excl;
        reverse_on = rev;
    endfunction

    function int pending();
        return sums_due.size();
    endfunction

    function run_t widen_add(run_t s, logic [15:0] b);
        run_t               r;
        logic signed [63:0] mag;
        r = s;
        if (b[14:10] == 5'd31) begin
            if (b[9:0] != 10'd0) begin
                r.nan_seen = 1'b1;
            end else if (b[15]) begin
                r.ninf = 1'b1;
            end else begin
                r.pinf = 1'b1;
            end
        end else begin
            if (b[14:10] == 5'd0) begin
                mag = 64'(b[9:0]);
            end else begin
                mag = 64'({1'b1, b[9:0]}) << (b[14:10] - 5'd1);
            end
            r.acc = b[15] ? r.acc - mag : r.acc + mag;
        end
        return r;
    endfunction

    // Round to fp16 nearest-even; too large a magnitude saturates to infinity.
    function logic [15:0] round_to_half(run_t s);
        logic [63:0] mag;
        logic [63:0] m;
        logic [63:0] rem;
        logic [63:0] half;
        logic [15:0] sgn;
        int          msb;
        int          sh;
        if (s.nan_seen || (s.pinf && s.ninf)) begin
            return rps_pkg::FP16_QNAN;
        end
        if (s.pinf) begin
            return rps_pkg::FP16_PINF;
        end
        if (s.ninf) begin
            return rps_pkg::FP16_NINF;
        end
        if (s.acc == 0) begin
            return 16'h0000;
        end
        sgn = (s.acc < 0) ? 16'h8000 : 16'h0000;
        mag = (s.acc < 0) ? -s.acc : s.acc;
        if (mag < 64'd2048) begin
            return sgn | mag[15:0];
        end
        msb = 63;
        while (!mag[msb]) begin
            msb--;
        end
        sh   = msb - 10;
        m    = mag >> sh;
        rem  = mag & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && m[0])) begin
            m = m + 64'd1;
        end
        if (m == 64'd2048) begin
            m = 64'd1024;
            sh++;
        end
        if (sh + 1 >= 31) begin
            return sgn | rps_pkg::FP16_PINF;
        end
        return sgn | {1'b0, 5'(sh + 1), m[9:0]};
    endfunction

    // Take one accepted element and queue the sums it produces.
    function void note_element(logic [15:0] v);
        int          len;
        int          pos;
        bit          last;
        run_t        tail;
        logic [15:0] r;
        len = int'(row_len);
        if (len < 1) begin
            len = 1;
        end
        if (len > rps_pkg::MAX_ROW) begin
            len = rps_pkg::MAX_ROW;
        end
        pos  = taken;
        last = (pos + 1 >= len);
        row_store[pos] = v;
        if (!reverse_on) begin
            if (excl_on) begin
                r   = round_to_half(fwd);
                fwd = widen_add(fwd, v);
            end else begin
                fwd = widen_add(fwd, v);
                r   = round_to_half(fwd);
            end
            sums_due.push_back({r, 6'(pos), last});
        end else begin
            fwd = widen_add(fwd, v);
            if (last) begin
                tail = '0;
                for (int j = pos; j >= 0; j--) begin
                    if (excl_on) begin
                        r    = round_to_half(tail);
                        tail = widen_add(tail, row_store[j]);
                    end else begin
                        tail = widen_add(tail, row_store[j]);
                        r    = round_to_half(tail);
                    end
                    sums_due.push_back({r, 6'(j), (j == 0)});
                end
            end
        end
        if (last) begin
            fwd   = '0;
            taken = 0;
        end else begin
            taken = pos + 1;
        end
    endfunction

    function void check_output(logic [15:0] sum, logic [5:0] pos, logic last);
        scan_out_t want;
        if (sums_due.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("unexpected output: sum=%h position=%0d row_last=%b",
                         sum, pos, last);
            end
            return;
        end
        want = sums_due.pop_front();
        if (want.sum !== sum || want.pos !== pos || want.last !== last) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch: expected sum=%h position=%0d row_last=%b,",
                         want.sum, want.pos, want.last);
                $display("          got sum=%h position=%0d row_last=%b",
                         sum, pos, last);
            end
        end
    endfunction
endclass

module tb_top;

    localparam int STALL_LIMIT = 500;   // cycles without any handshake before giving up
    localparam int SETTLE_CYC  = 16;    // covers the rounder pipe plus the accumulate step

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = 16'h0000;  // [15:0] value
    logic        m_tvalid;
    logic        m_tready  = 1'b1;
    logic [23:0] m_tdata;               // [15:0] sum, [21:16] position, [23:22] zero
    logic        m_tlast;               // row_last
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = rps_pkg::REG_ROW_LENGTH;
    logic [6:0]  cfg_wdata = 7'd0;

    fp16_scan_scoreboard sb = new();

    bit          gaps_on   = 1'b1;
    bit          stalls_on = 1'b1;
    int          rdy_hold  = 0;
    int unsigned still_cycles = 0;

    row_prefix_sum_fp16 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // Receiver: drop tready in random bursts while stalls are on.
    always @(posedge aclk) begin
        if (!aresetn || !stalls_on) begin
            rdy_hold <= 0;
            m_tready <= 1'b1;
        end else if (rdy_hold > 0) begin
            rdy_hold <= rdy_hold - 1;
            m_tready <= (rdy_hold == 1);
        end else if ($urandom_range(0, 5) == 0) begin
            rdy_hold <= $urandom_range(1, 6);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check every accepted result against the oldest queued sum.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_output(m_tdata[15:0], m_tdata[21:16], m_tlast);
        end
    end

    // Watchdog: end the run if nothing moves on any port for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            still_cycles <= 0;
        end else begin
            still_cycles <= still_cycles + 1;
            if (still_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Offer one request, hold it until taken, then hand it to the predictor.
    // tvalid is left high so back-to-back requests need no extra edge.
    task automatic send(logic [15:0] v);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        sb.note_element(v);
    endtask

    // Stop sending and wait until every queued sum has come out.
    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Reconfigure only when idle: drain the results, then let a reverse-mode
    // accumulate step that produced nothing finish as well.
    task automatic set_mode(int len, bit excl, bit rev);
        wait_results();
        repeat (SETTLE_CYC) @(posedge aclk);
        write_reg(rps_pkg::REG_ROW_LENGTH, 7'(len));
        write_reg(rps_pkg::REG_EXCLUSIVE, 7'(excl));
        write_reg(rps_pkg::REG_REVERSE, 7'(rev));
        cfg_wr_en <= 1'b0;
        sb.set_config(7'(len), excl, rev);
    endtask

    // Mostly moderate finite values so sums stay meaningful; some specials
    // and some fully random patterns.
    function automatic logic [15:0] pick_value();
        logic [15:0] specials [13];
        specials = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00, 16'h7C01, 16'hFFFF,
                     16'h7BFF, 16'hFBFF, 16'h0001, 16'h8001, 16'h03FF, 16'h0400};
        case ($urandom_range(0, 15))
            0: begin
                return specials[$urandom_range(0, 12)];
            end
            1, 2: begin
                return 16'($urandom_range(0, 65535));
            end
            default: begin
                return {1'($urandom_range(0, 1)), 5'($urandom_range(0, 20)),
                        10'($urandom_range(0, 1023))};
            end
        endcase
    endfunction

    initial begin
        int len;
        int eff;
        int n;
        int hold_at;
        int phase;
        int rnd_items;
        bit excl;
        bit rev;
        bit quiet;

        phase     = 0;
        rnd_items = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Forward inclusive: largest finite values, overflow to infinity, smallest subnormal.
        set_mode(4, 0, 0);
        send(16'h7BFF);
        send(16'h7BFF);
        send(16'hFBFF);
        send(16'h0001);
        // Forward exclusive: zero first, then +inf, then both infinities give NaN.
        set_mode(3, 1, 0);
        send(16'h7C00);
        send(16'hFC00);
        send(16'h0400);
        // Cancellation to an exact zero.
        set_mode(2, 0, 0);
        send(16'h3C00);
        send(16'hBC00);
        // Length 0 acts as 1: every element is its own row.
        set_mode(0, 0, 0);
        send(16'h7E00);
        send(16'h8000);
        send(16'hFFFF);
        // Reverse inclusive and reverse exclusive drains.
        set_mode(3, 0, 1);
        send(16'h1400);
        send(16'h3C00);
        send(16'hC000);
        set_mode(3, 1, 1);
        send(16'h5BFF);
        send(16'h0001);
        send(16'h3555);
        // Length lowered below the elements taken: the next element ends the row.
        set_mode(6, 0, 0);
        send(16'h3800);
        send(16'h03FF);
        send(16'hB555);
        set_mode(2, 0, 0);
        send(16'h4100);
        // Mode switched mid-row: reverse, forward exclusive, back to reverse at the end.
        set_mode(4, 0, 1);
        send(16'h2E66);
        send(16'hC8F0);
        set_mode(4, 1, 0);
        send(16'h0200);
        set_mode(4, 0, 1);
        send(16'h6A00);

        // Random phases; rows mostly complete in reverse mode, some cut short.
        while (rnd_items < 185) begin
            quiet     = (rnd_items >= 150);
            gaps_on   = !quiet && ($urandom_range(0, 3) != 0);
            stalls_on = !quiet && ($urandom_range(0, 3) != 0);
            excl      = $urandom_range(0, 1);
            rev       = $urandom_range(0, 1);
            if (phase == 0) begin
                len = 127;
                rev = 1'b1;
            end else if (phase == 1) begin
                len = 64;
                rev = 1'b0;
            end else begin
                case ($urandom_range(0, 9))
                    0: begin
                        len = 0;
                    end
                    1: begin
                        len = 64;
                    end
                    2: begin
                        len = $urandom_range(65, 127);
                    end
                    3: begin
                        len = $urandom_range(9, 63);
                    end
                    default: begin
                        len = $urandom_range(1, 8);
                    end
                endcase
            end
            eff = (len < 1) ? 1 : ((len > rps_pkg::MAX_ROW) ? rps_pkg::MAX_ROW : len);
            if (rev) begin
                n = eff * ((eff > 16) ? 1 : $urandom_range(1, 3));
            end else begin
                n = $urandom_range(4, 24);
            end
            if (phase > 1 && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 20);
            end
            hold_at = (phase % 3 == 1) ? $urandom_range(0, n - 1) : -1;
            set_mode(len, excl, rev);
            for (int i = 0; i < n; i++) begin
                // Hold off the sender until the output side has fully drained.
                if (i == hold_at) begin
                    wait_results();
                end
                send(pick_value());
            end
            rnd_items += n;
            phase++;
        end

        wait_results();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- row_prefix_sum_fp16.f -----
design/rps_pkg.sv
design/rps_row_mem.sv
design/rps_fp16_round.sv
design/row_prefix_sum_fp16.sv
test/tb_top.sv
